// ===== design/rlbt_pkg.sv =====
// Shared types and codes for the run-length bitset table.
// Holds the cell command codes, the per-cell flag struct and default sizes.
// No dependencies.
`default_nettype none

package rlbt_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int POS_BITS_DEF = 32;
    localparam int IN_POS_W     = 32;
    localparam int EXT_POS_W    = 64;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_HOLD = 3'd0;   // keep everything
    localparam t_cmd CMD_CMP  = 3'd1;   // compare stored pair against position
    localparam t_cmd CMD_INS  = 3'd2;   // open a new pair at the position
    localparam t_cmd CMD_MRG  = 3'd3;   // join the first two touched runs
    localparam t_cmd CMD_FIX  = 3'd4;   // widen the single touched run

    typedef struct packed {
        logic below;    // run ends before the position
        logic touch;    // run overlaps or abuts [p, p+1)
        logic hit;      // position lies inside the run
    } t_cell_flags;

endpackage

`default_nettype wire

// ===== design/rlbt_cell.sv =====
// One cell of the boundary chain: holds one run of ones as a start/end pair.
// Compares against the position, then shifts, inserts or merges with neighbors.
// Depends on rlbt_pkg.
`default_nettype none

module rlbt_cell
    import rlbt_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire t_cmd                i_cmd,
    input  wire logic                i_vld,
    input  wire logic [POS_BITS-1:0] i_p,
    input  wire logic [POS_BITS-1:0] i_q,
    input  wire t_cell_flags         i_prev_flags,
    input  wire logic [POS_BITS-1:0] i_prev_lo,
    input  wire logic [POS_BITS-1:0] i_prev_hi,
    input  wire logic [POS_BITS-1:0] i_next_lo,
    input  wire logic [POS_BITS-1:0] i_next_hi,
    output t_cell_flags              o_flags,
    output logic [POS_BITS-1:0]      o_lo,
    output logic [POS_BITS-1:0]      o_hi
);

    logic [POS_BITS-1:0] r_lo, r_hi;
    logic [POS_BITS-1:0] n_lo, n_hi;
    t_cell_flags         r_flags;
    t_cell_flags         n_flags;
    logic                w_end_below;
    logic                w_is_first;
    logic                w_past_first;

    assign w_end_below  = r_hi < i_p;
    // first run not ending before p; the previous cell tells us where that is
    assign w_is_first   = !r_flags.below && i_prev_flags.below;
    assign w_past_first = !i_prev_flags.below;

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_flags = r_flags;
        unique case (i_cmd)
            CMD_HOLD: begin
            end
            CMD_CMP: begin
                n_flags.below = i_vld && w_end_below;
                n_flags.touch = i_vld && (r_lo <= i_q) && !w_end_below;
                n_flags.hit   = i_vld && (r_lo <= i_p) && (i_p < r_hi);
            end
            CMD_INS: begin
                if (w_is_first) begin
                    n_lo = i_p;
                    n_hi = i_q;
                end else if (w_past_first) begin
                    n_lo = i_prev_lo;
                    n_hi = i_prev_hi;
                end
            end
            CMD_MRG: begin
                if (w_is_first) begin
                    n_hi = i_next_hi;
                end else if (w_past_first) begin
                    n_lo = i_next_lo;
                    n_hi = i_next_hi;
                end
            end
            CMD_FIX: begin
                if (r_flags.touch) begin
                    n_lo = (i_p < r_lo) ? i_p : r_lo;
                    n_hi = (i_q > r_hi) ? i_q : r_hi;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_flags <= n_flags;
    end

    assign o_flags = r_flags;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

endmodule

`default_nettype wire

// ===== design/run_length_bitset_table.sv =====
// Run-length bitset table: a chain of DEPTH/2 cells, each one run of ones.
// Cells compare in S_IDLE and the result is registered in S_ACT; a set joining
// several runs passes S_ACT then S_CMP for each merge step. The input stalls outside
// S_IDLE, so a new word waits until the last is done; S_ACT holds on output stall.
// Reset clears the boundary count; stored boundaries are left as they are and
// need no clearing pass, since cells past the count are never observed.
`default_nettype none

module run_length_bitset_table
    import rlbt_pkg::*;
#(
    parameter  int DEPTH    = DEPTH_DEF,
    parameter  int POS_BITS = POS_BITS_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_kind,
    input  wire logic [IN_POS_W-1:0] i_position,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_bit_value,
    output logic                     o_status,
    output logic [CNT_W-1:0]         o_boundary_total
);

    localparam int PAIRS = DEPTH / 2;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_kind;
    logic [POS_BITS-1:0] r_p;
    logic                r_out_bit, r_out_st;
    logic [CNT_W-1:0]    r_out_cnt;

    logic [EXT_POS_W-1:0] w_ext_pos;
    logic [POS_BITS-1:0]  w_p, w_q;
    t_cmd                 w_cmd;
    logic                 w_res, w_res_bit, w_res_st;
    logic                 w_full, w_any_hit, w_any_touch, w_multi;

    logic [POS_BITS-1:0] w_lo [PAIRS];
    logic [POS_BITS-1:0] w_hi [PAIRS];
    t_cell_flags         w_flags [PAIRS];
    logic [PAIRS-1:0]    w_hit_v, w_touch_v, w_adj_v;

    assign w_ext_pos = {{(EXT_POS_W - IN_POS_W){1'b0}}, i_position};
    assign w_p       = (r_state == S_IDLE) ? w_ext_pos[POS_BITS-1:0] : r_p;
    assign w_q       = w_p + POS_BITS'(1);
    assign w_full    = r_count > CNT_W'(DEPTH - 2);

    for (genvar j = 0; j < PAIRS; j++) begin : g_cell
        t_cell_flags         w_pf;
        logic [POS_BITS-1:0] w_plo, w_phi, w_nlo, w_nhi;
        logic                w_vld;

        if (j == 0) begin : g_head
            assign w_pf  = '{below: 1'b1, touch: 1'b0, hit: 1'b0};
            assign w_plo = '0;
            assign w_phi = '0;
        end else begin : g_body
            assign w_pf  = w_flags[j-1];
            assign w_plo = w_lo[j-1];
            assign w_phi = w_hi[j-1];
        end

        if (j == PAIRS - 1) begin : g_tail
            assign w_nlo      = '0;
            assign w_nhi      = '0;
            assign w_adj_v[j] = 1'b0;
        end else begin : g_link
            assign w_nlo      = w_lo[j+1];
            assign w_nhi      = w_hi[j+1];
            assign w_adj_v[j] = w_flags[j].touch && w_flags[j+1].touch;
        end

        assign w_vld        = r_count > CNT_W'(2 * j);
        assign w_hit_v[j]   = w_flags[j].hit;
        assign w_touch_v[j] = w_flags[j].touch;

        rlbt_cell #(
            .POS_BITS (POS_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_vld        (w_vld),
            .i_p          (w_p),
            .i_q          (w_q),
            .i_prev_flags (w_pf),
            .i_prev_lo    (w_plo),
            .i_prev_hi    (w_phi),
            .i_next_lo    (w_nlo),
            .i_next_hi    (w_nhi),
            .o_flags      (w_flags[j]),
            .o_lo         (w_lo[j]),
            .o_hi         (w_hi[j])
        );
    end

    assign w_any_hit   = |w_hit_v;
    assign w_any_touch = |w_touch_v;
    assign w_multi     = |w_adj_v;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        w_cmd     = CMD_HOLD;
        w_res     = 1'b0;
        w_res_bit = 1'b0;
        w_res_st  = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                w_cmd = CMD_CMP;
                if (i_valid) begin
                    n_state = S_ACT;
                end
            end
            S_CMP: begin
                w_cmd   = CMD_CMP;
                n_state = S_ACT;
            end
            S_ACT: begin
                // hold while the previous word still waits downstream
                if (!(o_valid && i_stall)) begin
                    if (r_kind == KIND_READ) begin
                        w_res     = 1'b1;
                        w_res_bit = w_any_hit;
                        n_state   = S_IDLE;
                    end else if (r_p == POS_MAX) begin
                        w_res   = 1'b1;
                        n_state = S_IDLE;
                    end else if (w_multi) begin
                        // drop one run per step, then compare again
                        w_cmd   = CMD_MRG;
                        n_count = r_count - CNT_W'(2);
                        n_state = S_CMP;
                    end else if (w_any_touch) begin
                        w_cmd     = CMD_FIX;
                        w_res     = 1'b1;
                        w_res_bit = 1'b1;
                        n_state   = S_IDLE;
                    end else if (w_full) begin
                        w_res     = 1'b1;
                        w_res_st  = ST_FULL;
                        w_res_bit = w_any_hit;
                        n_state   = S_IDLE;
                    end else begin
                        w_cmd     = CMD_INS;
                        n_count   = r_count + CNT_W'(2);
                        w_res     = 1'b1;
                        w_res_bit = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_res) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind;
            r_p    <= w_ext_pos[POS_BITS-1:0];
        end
        if (w_res) begin
            r_out_bit <= w_res_bit;
            r_out_st  <= w_res_st;
            r_out_cnt <= n_count;
        end
    end

    assign o_stall          = r_state != S_IDLE;
    assign o_bit_value      = r_out_bit;
    assign o_status         = r_out_st;
    assign o_boundary_total = r_out_cnt;

endmodule

`default_nettype wire
